// ----- sv/bpa_pkg.sv -----
// ============================================================================
// bpa_pkg - shared types and codes for the buddy page allocator
// Command, status, configuration register and sequencer state codes used by the allocator files.
// ============================================================================
`default_nettype none

package bpa_pkg;

    // Page geometry
    localparam int PAGE_SHIFT = 12;

    // Command codes (s_axis_tuser)
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_BELOW = 2'd2;
    localparam logic [1:0] CMD_FREE  = 2'd3;

    // Status codes (m_axis_tuser)
    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_REJECT = 2'd1;
    localparam logic [1:0] STAT_NONE   = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_LOW_RESERVED = 2'd0;
    localparam logic [1:0] REG_KERNEL_START = 2'd1;
    localparam logic [1:0] REG_KERNEL_END   = 2'd2;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_ORDER,
        S_ADD_PREP,
        S_ADD_SEG,
        S_ADD_BLK,
        S_ADD_ORD,
        S_ADD_PUSH,
        S_ALLOC_SCAN,
        S_ALLOC_RD,
        S_BELOW_LIST,
        S_BELOW_ENT,
        S_BELOW_CHK,
        S_FREE_TAKE,
        S_FREE_ENT,
        S_FREE_CHK,
        S_FREE_PUSH,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SPLIT_DEC,
        S_SPLIT_PUSH,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- sv/bpa_store.sv -----
// ============================================================================
// bpa_store - free block page number store
// Single write port, single read port, registered read data, no reset.
// ============================================================================
`default_nettype none

module bpa_store #(
    parameter int DATA_W = 36,
    parameter int ADDR_W = 13,
    parameter int DEPTH  = 5376
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/buddy_page_allocator_top.sv -----
// ============================================================================
// buddy_page_allocator_top - buddy page allocator
// Per-order LIFO free lists of page numbers with add, alloc, alloc-below
// and free commands, run by one small sequencer over a shared store.
// ============================================================================
// Usage:
//   s_axis carries one command beat (command in tuser, address, page_count
//   and limit in tdata). m_axis returns exactly one result beat per command
//   (status in tuser, block_address in tdata). cfg writes the low reserved
//   page count and the kernel window; write it only while the block is idle.
//   One command is in work at a time; s_axis_tready is high only when idle.
//   Latency depends on the command: the order search steps one order at a
//   time; add range grows each block in S_ADD_ORD and pushes it in
//   S_ADD_PUSH; alloc scans one order per cycle and splits each order in
//   S_SPLIT_DEC then S_SPLIT_PUSH; alloc-below and free read list entries
//   through the store's one read port, one entry per ENT/CHK state pair,
//   and unlinking moves each entry down via S_SHIFT_RD then S_SHIFT_WR.
//   The result sits in an output register; if m_axis stalls, the sequencer
//   holds in its final state and accepts nothing further.
//   Reset clears all list counts, so every list starts empty; the store
//   itself needs no clearing. Registers reset to 256 / 0 / 0.
// ============================================================================
`default_nettype none

module buddy_page_allocator_top #(
    parameter int MAX_ORDER        = 20,
    parameter int BLOCKS_PER_ORDER = 256,
    parameter int ADDRESS_BITS     = 48
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // command beats
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [135:0] s_axis_tdata,  // address[47:0], page_count[83:48],
                                             // limit[131:84], zero pad
    input  wire logic [1:0]   s_axis_tuser,  // command
    // result beats
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [47:0]  m_axis_tdata,  // block_address
    output logic      [1:0]   m_axis_tuser,  // status
    // configuration writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [47:0]  cfg_data
);

    localparam int LIST_COUNT = MAX_ORDER + 1;
    localparam int LW         = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
    localparam int OCW        = $clog2(MAX_ORDER + 2);
    localparam int IW         = $clog2(BLOCKS_PER_ORDER);
    localparam int CNT_W      = $clog2(BLOCKS_PER_ORDER + 1);
    localparam int PAGE_BITS  = ADDRESS_BITS - bpa_pkg::PAGE_SHIFT;
    localparam int PAGE_W     = (PAGE_BITS < 37) ? PAGE_BITS : 37;
    localparam int EW         = 38;
    localparam int CW         = 51;
    localparam int MAW        = LW + IW;
    localparam int MEM_DEPTH  = LIST_COUNT * (2 ** IW);

    localparam logic [OCW-1:0]   MAX_O    = OCW'(MAX_ORDER);
    localparam logic [CNT_W-1:0] BPO_C    = CNT_W'(BLOCKS_PER_ORDER);
    localparam logic [EW-1:0]    TOP_PAGE = EW'(1) << PAGE_W;
    localparam logic [EW-1:0]    HI_MASK  = ~((EW'(1) << MAX_ORDER) - EW'(1));
    localparam logic [47:0]      AMASK    = (ADDRESS_BITS >= 48) ? 48'hFFFF_FFFF_FFFF :
                                            ((48'd1 << ADDRESS_BITS) - 48'd1);

    bpa_pkg::state_t state_reg, state_next;

    logic [1:0]       cmd_reg;
    logic [47:0]      addr_reg;
    logic [35:0]      count_reg;
    logic [47:0]      lim_reg;
    logic [OCW-1:0]   cur_reg, cur_next;
    logic [OCW-1:0]   ord_reg, ord_next;
    logic [EW-1:0]    pw_reg, pw_next;
    logic [EW-1:0]    s_reg, s_next;
    logic [EW-1:0]    e_reg, e_next;
    logic [EW-1:0]    bs_reg, bs_next;
    logic [EW-1:0]    be_reg, be_next;
    logic             pend_reg, pend_next;
    logic [EW-1:0]    ks_reg, ks_next;
    logic [EW-1:0]    ke_reg, ke_next;
    logic [EW-1:0]    rem_reg, rem_next;
    logic [EW-1:0]    page_reg, page_next;
    logic [EW-1:0]    buddy_reg, buddy_next;
    logic [CW-1:0]    size_reg, size_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             full_reg, full_next;
    logic [1:0]       stat_reg, stat_next;
    logic [47:0]      res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_stat_reg, out_stat_next;
    logic [47:0]      out_res_reg, out_res_next;
    logic [15:0]      low_reg;
    logic [47:0]      kst_reg;
    logic [47:0]      ken_reg;
    logic [CNT_W-1:0] lcnt_reg [LIST_COUNT];

    logic             in_fire;
    logic [LW-1:0]    cur_lw;
    logic [CNT_W-1:0] cnt_cur;
    logic             cnt_inc;
    logic             cnt_dec;
    logic             push_en;
    logic [EW-1:0]    push_page;
    logic             mem_we;
    logic [MAW-1:0]   mem_waddr;
    logic [PAGE_W-1:0] mem_wdata;
    logic             mem_re;
    logic [MAW-1:0]   mem_raddr;
    logic [PAGE_W-1:0] mem_rdata;
    logic             shift_wr;
    logic             st_we;
    logic [MAW-1:0]   st_waddr;
    logic [PAGE_W-1:0] st_wdata;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == bpa_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg;
    assign m_axis_tuser  = out_stat_reg;
    assign cfg_ready     = 1'b1;

    // Count of the list under the sequencer's order
    assign cur_lw  = cur_reg[LW-1:0];
    assign cnt_cur = (cur_reg <= MAX_O) ? lcnt_reg[cur_lw] : '0;

    // Free block store
    bpa_store #(
        .DATA_W (PAGE_W),
        .ADDR_W (MAW),
        .DEPTH  (MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg <= 16'd256;
            kst_reg <= '0;
            ken_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bpa_pkg::REG_LOW_RESERVED: low_reg <= cfg_data[15:0];
                bpa_pkg::REG_KERNEL_START: kst_reg <= cfg_data;
                bpa_pkg::REG_KERNEL_END:   ken_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // List counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIST_COUNT; i++)
            begin
                lcnt_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < LIST_COUNT; i++)
            begin
                if (cur_reg == OCW'(i))
                begin
                    if (cnt_inc)
                    begin
                        lcnt_reg[i] <= lcnt_reg[i] + CNT_W'(1);
                    end
                    else if (cnt_dec)
                    begin
                        lcnt_reg[i] <= lcnt_reg[i] - CNT_W'(1);
                    end
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpa_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg   <= s_axis_tuser;
            addr_reg  <= s_axis_tdata[47:0] & AMASK;
            count_reg <= s_axis_tdata[83:48];
            lim_reg   <= s_axis_tdata[131:84];
        end
        cur_reg      <= cur_next;
        ord_reg      <= ord_next;
        pw_reg       <= pw_next;
        s_reg        <= s_next;
        e_reg        <= e_next;
        bs_reg       <= bs_next;
        be_reg       <= be_next;
        pend_reg     <= pend_next;
        ks_reg       <= ks_next;
        ke_reg       <= ke_next;
        rem_reg      <= rem_next;
        page_reg     <= page_next;
        buddy_reg    <= buddy_next;
        size_reg     <= size_next;
        idx_reg      <= idx_next;
        j_reg        <= j_next;
        full_reg     <= full_next;
        stat_reg     <= stat_next;
        res_reg      <= res_next;
        out_stat_reg <= out_stat_next;
        out_res_reg  <= out_res_next;
    end

    // Push onto the list of the current order
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {cur_lw, cnt_cur[IW-1:0]};
        mem_wdata = push_page[PAGE_W-1:0];
        cnt_inc   = 1'b0;
        if (push_en && (cnt_cur != BPO_C))
        begin
            mem_we  = 1'b1;
            cnt_inc = 1'b1;
        end
    end

    // Sequencer
    always_comb
    begin
        logic [EW-1:0]    ap;
        logic [48:0]      ken_up;
        logic [EW-1:0]    et;
        logic [EW-1:0]    low_e;
        logic [EW-1:0]    smax;
        logic [EW-1:0]    nsz;
        logic [EW-1:0]    rd_e;
        logic [CW-1:0]    rd_a;
        logic [CNT_W-1:0] idx_m1;
        logic [CNT_W-1:0] j_p1;

        ap     = EW'(addr_reg[47:12]);
        ken_up = {1'b0, ken_reg} + 49'd4095;
        et     = (e_reg > TOP_PAGE) ? TOP_PAGE : e_reg;
        low_e  = EW'(low_reg);
        smax   = (s_reg < low_e) ? low_e : s_reg;
        nsz    = pw_reg << 1;
        rd_e   = EW'(mem_rdata);
        rd_a   = CW'(mem_rdata) << bpa_pkg::PAGE_SHIFT;
        idx_m1 = idx_reg - CNT_W'(1);
        j_p1   = j_reg + CNT_W'(1);

        state_next     = state_reg;
        cur_next       = cur_reg;
        ord_next       = ord_reg;
        pw_next        = pw_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        bs_next        = bs_reg;
        be_next        = be_reg;
        pend_next      = pend_reg;
        ks_next        = ks_reg;
        ke_next        = ke_reg;
        rem_next       = rem_reg;
        page_next      = page_reg;
        buddy_next     = buddy_reg;
        size_next      = size_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        full_next      = full_reg;
        stat_next      = stat_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_stat_next  = out_stat_reg;
        out_res_next   = out_res_reg;
        push_en        = 1'b0;
        push_page      = s_reg;
        cnt_dec        = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = {cur_lw, idx_m1[IW-1:0]};

        // Output register drains independently
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            bpa_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    full_next  = 1'b0;
                    res_next   = '0;
                    state_next = bpa_pkg::S_START;
                end
            end

            bpa_pkg::S_START:
            begin
                if (count_reg == '0)
                begin
                    stat_next  = bpa_pkg::STAT_REJECT;
                    state_next = bpa_pkg::S_DONE;
                end
                else if (cmd_reg == bpa_pkg::CMD_ADD)
                begin
                    s_next     = ap + EW'(addr_reg[11:0] != 12'd0);
                    e_next     = ap + EW'(count_reg);
                    ks_next    = EW'(kst_reg[47:12]);
                    ke_next    = EW'(ken_up[48:12]);
                    state_next = bpa_pkg::S_ADD_PREP;
                end
                else
                begin
                    cur_next   = '0;
                    pw_next    = EW'(1);
                    state_next = bpa_pkg::S_ORDER;
                end
            end

            // Round the page count up to an order, one step a cycle
            bpa_pkg::S_ORDER:
            begin
                if ((cur_reg <= MAX_O) && (pw_reg < EW'(count_reg)))
                begin
                    cur_next = cur_reg + OCW'(1);
                    pw_next  = pw_reg << 1;
                end
                else if (cur_reg > MAX_O)
                begin
                    stat_next  = bpa_pkg::STAT_REJECT;
                    state_next = bpa_pkg::S_DONE;
                end
                else
                begin
                    ord_next = cur_reg;
                    case (cmd_reg)
                        bpa_pkg::CMD_ALLOC:
                        begin
                            state_next = bpa_pkg::S_ALLOC_SCAN;
                        end
                        bpa_pkg::CMD_BELOW:
                        begin
                            if (lim_reg == '0)
                            begin
                                stat_next  = bpa_pkg::STAT_REJECT;
                                state_next = bpa_pkg::S_DONE;
                            end
                            else
                            begin
                                size_next  = CW'(pw_reg) << bpa_pkg::PAGE_SHIFT;
                                state_next = bpa_pkg::S_BELOW_LIST;
                            end
                        end
                        default:
                        begin
                            if ((addr_reg == '0) || (addr_reg[11:0] != 12'd0))
                            begin
                                stat_next  = bpa_pkg::STAT_REJECT;
                                state_next = bpa_pkg::S_DONE;
                            end
                            else
                            begin
                                page_next  = ap;
                                state_next = bpa_pkg::S_FREE_TAKE;
                            end
                        end
                    endcase
                end
            end

            // Clamp the range and cut out the kernel window
            bpa_pkg::S_ADD_PREP:
            begin
                pend_next = 1'b0;
                bs_next   = ke_reg;
                be_next   = et;
                if (!(et > s_reg))
                begin
                    stat_next  = bpa_pkg::STAT_DONE;
                    state_next = bpa_pkg::S_DONE;
                end
                else if ((ke_reg <= ks_reg) || (et <= ks_reg) || (s_reg >= ke_reg))
                begin
                    e_next     = et;
                    state_next = bpa_pkg::S_ADD_SEG;
                end
                else if (s_reg < ks_reg)
                begin
                    e_next     = ks_reg;
                    pend_next  = (et > ke_reg);
                    state_next = bpa_pkg::S_ADD_SEG;
                end
                else if (et > ke_reg)
                begin
                    s_next     = ke_reg;
                    e_next     = et;
                    state_next = bpa_pkg::S_ADD_SEG;
                end
                else
                begin
                    stat_next  = bpa_pkg::STAT_DONE;
                    state_next = bpa_pkg::S_DONE;
                end
            end

            // Drop the low reserved pages from one segment
            bpa_pkg::S_ADD_SEG:
            begin
                if ((e_reg <= low_e) || (e_reg <= smax))
                begin
                    if (pend_reg)
                    begin
                        s_next    = bs_reg;
                        e_next    = be_reg;
                        pend_next = 1'b0;
                    end
                    else
                    begin
                        stat_next  = full_reg ? bpa_pkg::STAT_FULL : bpa_pkg::STAT_DONE;
                        state_next = bpa_pkg::S_DONE;
                    end
                end
                else
                begin
                    s_next     = smax;
                    state_next = bpa_pkg::S_ADD_BLK;
                end
            end

            bpa_pkg::S_ADD_BLK:
            begin
                if (s_reg >= e_reg)
                begin
                    if (pend_reg)
                    begin
                        s_next     = bs_reg;
                        e_next     = be_reg;
                        pend_next  = 1'b0;
                        state_next = bpa_pkg::S_ADD_SEG;
                    end
                    else
                    begin
                        stat_next  = full_reg ? bpa_pkg::STAT_FULL : bpa_pkg::STAT_DONE;
                        state_next = bpa_pkg::S_DONE;
                    end
                end
                else
                begin
                    rem_next   = e_reg - s_reg;
                    cur_next   = '0;
                    pw_next    = EW'(1);
                    state_next = bpa_pkg::S_ADD_ORD;
                end
            end

            // Grow the block while it fits and stays aligned
            bpa_pkg::S_ADD_ORD:
            begin
                if ((cur_reg < MAX_O) && (nsz <= rem_reg)
                    && ((s_reg & (nsz - EW'(1))) == '0))
                begin
                    cur_next = cur_reg + OCW'(1);
                    pw_next  = nsz;
                end
                else
                begin
                    state_next = bpa_pkg::S_ADD_PUSH;
                end
            end

            bpa_pkg::S_ADD_PUSH:
            begin
                if ((cur_reg == MAX_O) && (cnt_cur == BPO_C))
                begin
                    // top list full: skip every whole top-order block at once
                    s_next    = s_reg + (rem_reg & HI_MASK);
                    full_next = 1'b1;
                end
                else
                begin
                    push_en   = 1'b1;
                    push_page = s_reg;
                    if (cnt_cur == BPO_C)
                    begin
                        full_next = 1'b1;
                    end
                    s_next = s_reg + pw_reg;
                end
                state_next = bpa_pkg::S_ADD_BLK;
            end

            // Smallest non-empty list at or above the order
            bpa_pkg::S_ALLOC_SCAN:
            begin
                if (cur_reg > MAX_O)
                begin
                    stat_next  = bpa_pkg::STAT_NONE;
                    state_next = bpa_pkg::S_DONE;
                end
                else if (cnt_cur == '0)
                begin
                    cur_next = cur_reg + OCW'(1);
                    pw_next  = pw_reg << 1;
                end
                else
                begin
                    idx_m1     = cnt_cur - CNT_W'(1);
                    mem_re     = 1'b1;
                    mem_raddr  = {cur_lw, idx_m1[IW-1:0]};
                    cnt_dec    = 1'b1;
                    state_next = bpa_pkg::S_ALLOC_RD;
                end
            end

            bpa_pkg::S_ALLOC_RD:
            begin
                page_next  = rd_e;
                res_next   = rd_a[47:0];
                state_next = bpa_pkg::S_SPLIT_DEC;
            end

            // Alloc-below: walk lists ascending, each head first
            bpa_pkg::S_BELOW_LIST:
            begin
                if (cur_reg > MAX_O)
                begin
                    stat_next  = bpa_pkg::STAT_NONE;
                    state_next = bpa_pkg::S_DONE;
                end
                else
                begin
                    idx_next   = cnt_cur;
                    state_next = bpa_pkg::S_BELOW_ENT;
                end
            end

            bpa_pkg::S_BELOW_ENT:
            begin
                if (idx_reg == '0)
                begin
                    cur_next   = cur_reg + OCW'(1);
                    pw_next    = pw_reg << 1;
                    state_next = bpa_pkg::S_BELOW_LIST;
                end
                else
                begin
                    idx_next   = idx_m1;
                    mem_re     = 1'b1;
                    state_next = bpa_pkg::S_BELOW_CHK;
                end
            end

            bpa_pkg::S_BELOW_CHK:
            begin
                if ((rd_a + size_reg) <= CW'(lim_reg))
                begin
                    page_next  = rd_e;
                    res_next   = rd_a[47:0];
                    j_next     = idx_reg;
                    state_next = bpa_pkg::S_SHIFT_RD;
                end
                else
                begin
                    state_next = bpa_pkg::S_BELOW_ENT;
                end
            end

            // Free: look for the buddy in the list of the current order
            bpa_pkg::S_FREE_TAKE:
            begin
                if (cur_reg < MAX_O)
                begin
                    buddy_next = page_reg ^ pw_reg;
                    idx_next   = cnt_cur;
                    state_next = bpa_pkg::S_FREE_ENT;
                end
                else
                begin
                    state_next = bpa_pkg::S_FREE_PUSH;
                end
            end

            bpa_pkg::S_FREE_ENT:
            begin
                if (idx_reg == '0)
                begin
                    state_next = bpa_pkg::S_FREE_PUSH;
                end
                else
                begin
                    idx_next   = idx_m1;
                    mem_re     = 1'b1;
                    state_next = bpa_pkg::S_FREE_CHK;
                end
            end

            bpa_pkg::S_FREE_CHK:
            begin
                if (rd_e == buddy_reg)
                begin
                    if (buddy_reg < page_reg)
                    begin
                        page_next = buddy_reg;
                    end
                    j_next     = idx_reg;
                    state_next = bpa_pkg::S_SHIFT_RD;
                end
                else
                begin
                    state_next = bpa_pkg::S_FREE_ENT;
                end
            end

            bpa_pkg::S_FREE_PUSH:
            begin
                push_en    = 1'b1;
                push_page  = page_reg;
                stat_next  = (cnt_cur == BPO_C) ? bpa_pkg::STAT_FULL : bpa_pkg::STAT_DONE;
                state_next = bpa_pkg::S_DONE;
            end

            // Unlink entry j: move the entries above it down by one
            bpa_pkg::S_SHIFT_RD:
            begin
                if (j_p1 < cnt_cur)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = {cur_lw, j_p1[IW-1:0]};
                    state_next = bpa_pkg::S_SHIFT_WR;
                end
                else
                begin
                    cnt_dec = 1'b1;
                    if (cmd_reg == bpa_pkg::CMD_FREE)
                    begin
                        cur_next   = cur_reg + OCW'(1);
                        pw_next    = pw_reg << 1;
                        state_next = bpa_pkg::S_FREE_TAKE;
                    end
                    else
                    begin
                        state_next = bpa_pkg::S_SPLIT_DEC;
                    end
                end
            end

            bpa_pkg::S_SHIFT_WR:
            begin
                j_next     = j_p1;
                state_next = bpa_pkg::S_SHIFT_RD;
            end

            // Split down to the requested order, pushing upper halves
            bpa_pkg::S_SPLIT_DEC:
            begin
                if (cur_reg > ord_reg)
                begin
                    cur_next   = cur_reg - OCW'(1);
                    pw_next    = pw_reg >> 1;
                    state_next = bpa_pkg::S_SPLIT_PUSH;
                end
                else
                begin
                    stat_next  = full_reg ? bpa_pkg::STAT_FULL : bpa_pkg::STAT_DONE;
                    state_next = bpa_pkg::S_DONE;
                end
            end

            bpa_pkg::S_SPLIT_PUSH:
            begin
                push_en   = 1'b1;
                push_page = page_reg + pw_reg;
                if (cnt_cur == BPO_C)
                begin
                    full_next = 1'b1;
                end
                state_next = bpa_pkg::S_SPLIT_DEC;
            end

            // Hand the result to the output register
            bpa_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_res_next   = res_reg;
                    state_next     = bpa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bpa_pkg::S_IDLE;
            end
        endcase
    end

    // Shift-write happens with the data read in the previous cycle
    assign shift_wr = (state_reg == bpa_pkg::S_SHIFT_WR);

    // Final store write port selection
    always_comb
    begin
        st_we    = mem_we;
        st_waddr = mem_waddr;
        st_wdata = mem_wdata;
        if (shift_wr)
        begin
            st_we    = 1'b1;
            st_waddr = {cur_lw, j_reg[IW-1:0]};
            st_wdata = mem_rdata;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("command accepted while another is in work");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (cnt_cur < BPO_C))
        else $error("store write into a full list");

    a_reject_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == bpa_pkg::STAT_REJECT
                           || m_axis_tuser == bpa_pkg::STAT_NONE))
        |-> (m_axis_tdata == '0))
        else $error("failed request returned a block address");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_inc |=> (cnt_cur <= BPO_C) || $past(cur_reg) != cur_reg)
        else $error("list count beyond capacity");

endmodule

`default_nettype wire
